// ===== rtl/b64d_pkg.sv =====
`default_nettype none

package b64d_pkg;

    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned BYTE_W   = 8;

    // Depth of the queue between the character front and the byte back end.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_DASH    = 8'd45;
    localparam logic [7:0] CHAR_USCORE  = 8'h5F;

    localparam logic [SEXTET_W-1:0] SEXTET_DASH   = 6'd62;
    localparam logic [SEXTET_W-1:0] SEXTET_USCORE = 6'd63;
    localparam logic [SEXTET_W-1:0] LOWER_OFFSET  = 6'd26;
    localparam logic [SEXTET_W-1:0] DIGIT_OFFSET  = 6'd52;

    localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_THIRD  = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_FOURTH = 2'd3;

    // One classified character as it travels from the front to the back end.
    typedef struct packed {
        logic [SEXTET_W-1:0] sextet;
        logic                valid_char;
        logic                last;
    } char_entry_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_message;
        logic              bad_text;
    } result_t;

    // Maps one character to its sextet; invalid characters give zero.
    function automatic char_entry_t classify(input logic [7:0] ch, input logic last);
        char_entry_t e;
        logic [7:0]  diff;
        e.sextet     = '0;
        e.valid_char = 1'b1;
        e.last       = last;
        diff         = '0;
        if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            diff     = ch - CHAR_UPPER_A;
            e.sextet = diff[SEXTET_W-1:0];
        end else if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            diff     = ch - CHAR_LOWER_A;
            e.sextet = diff[SEXTET_W-1:0] + LOWER_OFFSET;
        end else if (ch inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
            diff     = ch - CHAR_DIGIT_0;
            e.sextet = diff[SEXTET_W-1:0] + DIGIT_OFFSET;
        end else if (ch == CHAR_DASH) begin
            e.sextet = SEXTET_DASH;
        end else if (ch == CHAR_USCORE) begin
            e.sextet = SEXTET_USCORE;
        end else begin
            e.valid_char = 1'b0;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/b64d_front.sv =====
`default_nettype none

module b64d_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_symbol,
    input  wire logic                 s_end_of_text,
    input  wire logic                 queue_full,
    output logic                      push,
    output b64d_pkg::char_entry_t     push_entry
);

    // Registered classification stage: the decoded character waits here
    // until the queue has room for it.
    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    b64d_pkg::char_entry_t stage_entry_reg;

    assign push    = stage_valid_reg && !queue_full;
    assign s_ready = !stage_valid_reg || !queue_full;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (push) begin
            stage_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
        if (s_valid && s_ready) begin
            stage_entry_reg <= b64d_pkg::classify(s_symbol, s_end_of_text);
        end
    end

    assign push_entry = stage_entry_reg;

endmodule

`default_nettype wire

// ===== rtl/b64d_queue.sv =====
`default_nettype none

module b64d_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire b64d_pkg::char_entry_t push_entry,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       not_empty,
    output b64d_pkg::char_entry_t      head_entry
);

    localparam int unsigned AW = b64d_pkg::QUEUE_AW;

    b64d_pkg::char_entry_t entry_reg [b64d_pkg::QUEUE_DEPTH];

    // Pointers carry one extra bit to tell full from empty.
    logic [AW:0] wr_ptr_reg;
    logic [AW:0] wr_ptr_next;
    logic [AW:0] rd_ptr_reg;
    logic [AW:0] rd_ptr_next;

    assign not_empty  = wr_ptr_reg != rd_ptr_reg;
    assign full       = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                        (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign head_entry = entry_reg[rd_ptr_reg[AW-1:0]];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push && !full) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && not_empty) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
        if (push && !full) begin
            entry_reg[wr_ptr_reg[AW-1:0]] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/b64d_back.sv =====
`default_nettype none

module b64d_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  not_empty,
    input  wire b64d_pkg::char_entry_t head_entry,
    output logic                       pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [7:0]                 m_data_byte,
    output logic                       m_end_of_message,
    output logic                       m_bad_text
);

    logic [b64d_pkg::PHASE_W-1:0]  phase_reg;
    logic [b64d_pkg::PHASE_W-1:0]  phase_next;
    logic [b64d_pkg::SEXTET_W-1:0] prev_reg;
    logic [b64d_pkg::SEXTET_W-1:0] prev_next;
    logic                          error_reg;
    logic                          error_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    b64d_pkg::result_t             out_reg;
    b64d_pkg::result_t             out_next;

    logic [b64d_pkg::BYTE_W-1:0]   assembled;
    logic                          error_now;
    logic                          emit;

    // A character is taken whenever the output register is free or is being
    // emptied in the same cycle.
    assign pop = not_empty && (!out_valid_reg || m_ready);

    always_comb begin
        case (phase_reg)
            b64d_pkg::PHASE_SECOND: assembled = {prev_reg, head_entry.sextet[5:4]};
            b64d_pkg::PHASE_THIRD:  assembled = {prev_reg[3:0], head_entry.sextet[5:2]};
            b64d_pkg::PHASE_FOURTH: assembled = {prev_reg[1:0], head_entry.sextet};
            default:                assembled = '0;
        endcase
    end

    always_comb begin
        error_now      = error_reg || !head_entry.valid_char;
        emit           = 1'b0;
        phase_next     = phase_reg;
        prev_next      = prev_reg;
        error_next     = error_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        if (pop) begin
            if (head_entry.last) begin
                emit                    = 1'b1;
                out_next.end_of_message = 1'b1;
                out_next.bad_text       = error_now || (phase_reg == b64d_pkg::PHASE_FIRST);
                out_next.data_byte      = out_next.bad_text ? '0 : assembled;
                phase_next              = b64d_pkg::PHASE_FIRST;
                prev_next               = '0;
                error_next              = 1'b0;
            end else begin
                emit                    = (phase_reg != b64d_pkg::PHASE_FIRST) && !error_now;
                out_next.end_of_message = 1'b0;
                out_next.bad_text       = 1'b0;
                out_next.data_byte      = assembled;
                phase_next              = phase_reg + 1'b1;
                prev_next               = head_entry.sextet;
                error_next              = error_now;
            end
            if (!emit) begin
                out_next = out_reg;
            end
            out_valid_next = emit || (out_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= b64d_pkg::PHASE_FIRST;
            prev_reg      <= '0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            prev_reg      <= prev_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_data_byte      = out_reg.data_byte;
    assign m_end_of_message = out_reg.end_of_message;
    assign m_bad_text       = out_reg.bad_text;

endmodule

`default_nettype wire

// ===== rtl/base64url_stream_decoder_top.sv =====
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_symbol[7:0], s_end_of_text
// m_        out        m_valid/m_ready    m_data_byte[7:0], m_end_of_message, m_bad_text
//
// One character is accepted per clock while s_ready is high. A character passes through the
// classification register, then the queue, then the output register that drives m_valid.
// The back end retires one queued character per cycle while its output register is free
// or m_ready is high.
// Reset (aresetn, synchronous, active low) empties the queue and clears phase,
// previous sextet and error flag. A stalled output lets the queue fill up to its
// four entries, and then the classification register, before s_ready drops.

module base64url_stream_decoder_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_symbol,
    input  wire logic       s_end_of_text,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_data_byte,
    output logic            m_end_of_message,
    output logic            m_bad_text
);

    logic                  push;
    logic                  queue_full;
    logic                  pop;
    logic                  queue_not_empty;
    b64d_pkg::char_entry_t push_entry;
    b64d_pkg::char_entry_t head_entry;

    b64d_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_symbol      (s_symbol),
        .s_end_of_text (s_end_of_text),
        .queue_full    (queue_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    b64d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .head_entry (head_entry)
    );

    b64d_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .not_empty        (queue_not_empty),
        .head_entry       (head_entry),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_byte      (m_data_byte),
        .m_end_of_message (m_end_of_message),
        .m_bad_text       (m_bad_text)
    );

endmodule

`default_nettype wire
